@@ src/breaker_current_voltage_rms_meter_assert.svh @@
// assertion macros for the breaker rms meter
`ifndef BREAKER_CURRENT_VOLTAGE_RMS_METER_ASSERT_SVH
`define BREAKER_CURRENT_VOLTAGE_RMS_METER_ASSERT_SVH

// property holds on every clock edge out of reset
`define BRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define BRK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/brkrms_pkg.sv @@
// types and constants of the breaker rms meter
`timescale 1ns / 1ps

package brkrms_pkg;

  localparam int ADC_W  = 16;
  localparam int DIV_W  = 26;
  localparam int CNT_W  = 5;
  localparam int ROOT_W = 16;
  localparam int RAD_W  = 32;
  localparam int SUB_W  = 19;
  localparam int NOW_W  = 27;
  localparam int RMS_W  = 26;
  localparam int CFG_IDX_W = 3;

  localparam logic [ADC_W-1:0] MILLI       = 16'd1000;
  localparam logic [ADC_W-1:0] LOW_SEL_MIN = 16'd100;
  localparam logic [ADC_W-1:0] LOW_SEL_MAX = 16'd65435;

  localparam logic [ADC_W-1:0] LG_OFFSET_RST = 16'd32768;
  localparam logic [ADC_W-1:0] LG_SCALE_RST  = 16'd874;
  localparam logic [ADC_W-1:0] HG_OFFSET_RST = 16'd32768;
  localparam logic [ADC_W-1:0] HG_SCALE_RST  = 16'd8738;
  localparam logic [ADC_W-1:0] MV_OFFSET_RST = 16'd32768;
  localparam logic [ADC_W-1:0] MV_SCALE_RST  = 16'd79;

  localparam logic [CNT_W-1:0] SQRT_STEPS_M1 = 5'd15;
  localparam logic [CNT_W-1:0] DIV_STEPS_M1  = 5'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LG_OFFSET = 3'd0,
    REG_LG_SCALE  = 3'd1,
    REG_HG_OFFSET = 3'd2,
    REG_HG_SCALE  = 3'd3,
    REG_MV_OFFSET = 3'd4,
    REG_MV_SCALE  = 3'd5
  } reg_idx_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SQ      = 10'b0000000010,
    S_ACC     = 10'b0000000100,
    S_SQRT_LD = 10'b0000001000,
    S_SQRT    = 10'b0000010000,
    S_MUL     = 10'b0000100000,
    S_DIV_LD  = 10'b0001000000,
    S_DIV     = 10'b0010000000,
    S_STORE   = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    JOB_CUR       = 3'd0,
    JOB_VOLT      = 3'd1,
    JOB_RMS_LO    = 3'd2,
    JOB_RMS_HI    = 3'd3,
    JOB_RMS_MAINS = 3'd4
  } job_t;

  typedef enum logic [1:0] {
    CH_LO    = 2'd0,
    CH_HI    = 2'd1,
    CH_MAINS = 2'd2
  } chan_t;

endpackage

@@ src/breaker_current_voltage_rms_meter.sv @@
// top level of the breaker current and voltage rms meter
`timescale 1ns / 1ps
`include "breaker_current_voltage_rms_meter_assert.svh"

// Breaker current and voltage RMS meter. Each request on the input stream carries
// three raw ADC codes (low-gain current, high-gain current, mains voltage). The
// offset-corrected squares are summed over a window of 2^WINDOW_LOG2 ticks; when
// a window closes each sum is averaged, square-rooted and scaled to mA or mV and
// held. Every request produces one result: instant current and voltage, the held
// RMS values, which current channel was used (tuser) and whether this tick
// closed the window (tlast). The low-gain channel is used while its code lies
// strictly between 100 and 65435. A scale register holding 0 acts as 1.
// Structure: one 16x16 multiplier and one 19-bit restoring subtract unit, shared
// under a sequencer. An ordinary tick forms the three squares and then runs two
// conversions, each a multiply by a thousand and the 26-step division producing
// one quotient bit per cycle; a closing tick first runs three RMS jobs, each of
// 16 square-root steps plus a conversion.
// The result sits in an output register, so the next request is taken while it
// waits; a further result stalls only if the previous one is still unread.
// Configuration is a plain write port, registers taken on any cycle with cfg_we.

module breaker_current_voltage_rms_meter
  import brkrms_pkg::*;
#(
  parameter int WINDOW_LOG2 = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADC_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // low_gain_sample[15:0], high_gain_sample[31:16], mains_sample[47:32]
  input  logic [47:0]          s_axis_tdata,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // current_now[26:0], voltage_now[53:27], current_rms[79:54], voltage_rms[105:80],
  // zero fill[111:106]
  output logic [111:0]         m_axis_tdata,
  // rms_updated
  output logic                 m_axis_tlast,
  // high_gain_used[0]
  output logic [0:0]           m_axis_tuser
);

  localparam int SUM_W = 2 * ADC_W + WINDOW_LOG2;

  // calibration registers
  logic [ADC_W-1:0] lg_offset, lg_scale, hg_offset, hg_scale, mv_offset, mv_scale;

  // sequencer
  state_t state;
  job_t   job;
  chan_t  ch;
  logic [CNT_W-1:0] cnt;

  // window state
  logic [SUM_W-1:0]       lo_sum, hi_sum, mv_sum;
  logic [WINDOW_LOG2-1:0] wcount;
  logic [RMS_W-1:0]       lo_held, hi_held, mv_held;

  // per-request payload
  logic [ADC_W-1:0] absd_lo, absd_hi, absd_mv;
  logic             neg_lo, neg_hi, neg_mv;
  logic             use_high, closed;
  logic [2*ADC_W-1:0] prod;
  logic [RAD_W-1:0]   rad;
  logic [ROOT_W:0]    rem;
  logic [ROOT_W-1:0]  root;
  logic [DIV_W-1:0]   dvd;
  logic [ADC_W-1:0]   drem;
  logic [NOW_W-1:0]   cur_now, volt_now;

  // output register
  logic             m_valid;
  logic [NOW_W-1:0] out_cur_now, out_volt_now;
  logic [RMS_W-1:0] out_cur_rms, out_volt_rms;
  logic             out_high, out_closed;

  logic [ADC_W-1:0] in_lo, in_hi, in_mv;
  logic             in_accept;

  assign in_lo = s_axis_tdata[15:0];
  assign in_hi = s_axis_tdata[31:16];
  assign in_mv = s_axis_tdata[47:32];
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // job operand and divisor
  logic [ADC_W-1:0] op, scale_raw, divisor;
  logic             job_neg;

  always_comb begin
    op = root;
    scale_raw = mv_scale;
    job_neg = 1'b0;
    case (job)
      JOB_CUR: begin
        op = use_high ? absd_hi : absd_lo;
        scale_raw = use_high ? hg_scale : lg_scale;
        job_neg = use_high ? neg_hi : neg_lo;
      end
      JOB_VOLT: begin
        op = absd_mv;
        job_neg = neg_mv;
      end
      JOB_RMS_LO:    scale_raw = lg_scale;
      JOB_RMS_HI:    scale_raw = hg_scale;
      JOB_RMS_MAINS: scale_raw = mv_scale;
      default: begin
        op = root;
        scale_raw = mv_scale;
      end
    endcase
  end

  assign divisor = (scale_raw == '0) ? ADC_W'(1) : scale_raw;

  // shared multiplier: squares, or operand times a thousand
  logic [ADC_W-1:0]   sq_op, mul_a, mul_b;
  logic [2*ADC_W-1:0] mul_p;

  always_comb begin
    case (ch)
      CH_LO:    sq_op = absd_lo;
      CH_HI:    sq_op = absd_hi;
      default:  sq_op = absd_mv;
    endcase
  end

  assign mul_a = (state == S_SQ) ? sq_op : op;
  assign mul_b = (state == S_SQ) ? sq_op : MILLI;
  assign mul_p = {{ADC_W{1'b0}}, mul_a} * {{ADC_W{1'b0}}, mul_b};

  // shared restoring subtract unit: square-root and division steps
  logic [SUB_W-1:0] sqrt_rem_sh, sub_a, sub_b;
  logic [ADC_W:0]   div_rem_sh;
  logic [SUB_W:0]   sub_d;
  logic             sub_ge;

  assign sqrt_rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign div_rem_sh  = {drem, dvd[DIV_W-1]};

  always_comb begin
    if (state == S_SQRT) begin
      sub_a = sqrt_rem_sh;
      sub_b = {2'b00, root[ROOT_W-2:0], 2'b01};
    end else begin
      sub_a = {{(SUB_W-ADC_W-1){1'b0}}, div_rem_sh};
      sub_b = {{(SUB_W-ADC_W){1'b0}}, divisor};
    end
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[SUB_W];

  // signed instant value from the unsigned quotient
  logic [NOW_W-1:0] q_ext, q_signed;
  assign q_ext    = {1'b0, dvd};
  assign q_signed = job_neg ? (~q_ext + NOW_W'(1)) : q_ext;

  // control, calibration and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= JOB_CUR;
      ch        <= CH_LO;
      m_valid   <= 1'b0;
      wcount    <= '0;
      lo_sum    <= '0;
      hi_sum    <= '0;
      mv_sum    <= '0;
      lo_held   <= '0;
      hi_held   <= '0;
      mv_held   <= '0;
      lg_offset <= LG_OFFSET_RST;
      lg_scale  <= LG_SCALE_RST;
      hg_offset <= HG_OFFSET_RST;
      hg_scale  <= HG_SCALE_RST;
      mv_offset <= MV_OFFSET_RST;
      mv_scale  <= MV_SCALE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LG_OFFSET: lg_offset <= cfg_data;
          REG_LG_SCALE:  lg_scale  <= cfg_data;
          REG_HG_OFFSET: hg_offset <= cfg_data;
          REG_HG_SCALE:  hg_scale  <= cfg_data;
          REG_MV_OFFSET: mv_offset <= cfg_data;
          REG_MV_SCALE:  mv_scale  <= cfg_data;
          default: ;
        endcase
      end
      // a result leaving while the next one is loaded is handled in S_DONE
      if (m_valid && m_axis_tready && (state != S_DONE)) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            ch    <= CH_LO;
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          case (ch)
            CH_LO:   lo_sum <= lo_sum + SUM_W'(prod);
            CH_HI:   hi_sum <= hi_sum + SUM_W'(prod);
            default: mv_sum <= mv_sum + SUM_W'(prod);
          endcase
          if (ch == CH_MAINS) begin
            // window closes on its last tick, after this tick's square is in
            wcount <= wcount + WINDOW_LOG2'(1);
            if (&wcount) begin
              job   <= JOB_RMS_LO;
              state <= S_SQRT_LD;
            end else begin
              job   <= JOB_CUR;
              state <= S_MUL;
            end
          end else begin
            ch    <= (ch == CH_LO) ? CH_HI : CH_MAINS;
            state <= S_SQ;
          end
        end
        S_SQRT_LD: begin
          case (job)
            JOB_RMS_LO: lo_sum <= '0;
            JOB_RMS_HI: hi_sum <= '0;
            default:    mv_sum <= '0;
          endcase
          state <= S_SQRT;
        end
        S_SQRT:   if (cnt == '0) state <= S_MUL;
        S_MUL:    state <= S_DIV_LD;
        S_DIV_LD: state <= S_DIV;
        S_DIV:    if (cnt == '0) state <= S_STORE;
        S_STORE: begin
          case (job)
            JOB_RMS_LO: begin
              lo_held <= dvd;
              job     <= JOB_RMS_HI;
              state   <= S_SQRT_LD;
            end
            JOB_RMS_HI: begin
              hi_held <= dvd;
              job     <= JOB_RMS_MAINS;
              state   <= S_SQRT_LD;
            end
            JOB_RMS_MAINS: begin
              mv_held <= dvd;
              job     <= JOB_CUR;
              state   <= S_MUL;
            end
            JOB_CUR: begin
              job   <= JOB_VOLT;
              state <= S_MUL;
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!m_valid || m_axis_tready) begin
            m_valid <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          neg_lo  <= in_lo < lg_offset;
          neg_hi  <= in_hi < hg_offset;
          neg_mv  <= in_mv < mv_offset;
          absd_lo <= (in_lo < lg_offset) ? (lg_offset - in_lo) : (in_lo - lg_offset);
          absd_hi <= (in_hi < hg_offset) ? (hg_offset - in_hi) : (in_hi - hg_offset);
          absd_mv <= (in_mv < mv_offset) ? (mv_offset - in_mv) : (in_mv - mv_offset);
          use_high <= !(in_lo inside {[LOW_SEL_MIN + 16'd1 : LOW_SEL_MAX - 16'd1]});
          closed  <= &wcount;
        end
      end
      S_SQ: prod <= mul_p;
      S_SQRT_LD: begin
        // mean of squares always fits 32 bits
        case (job)
          JOB_RMS_LO: rad <= lo_sum[SUM_W-1:WINDOW_LOG2];
          JOB_RMS_HI: rad <= hi_sum[SUM_W-1:WINDOW_LOG2];
          default:    rad <= mv_sum[SUM_W-1:WINDOW_LOG2];
        endcase
        rem  <= '0;
        root <= '0;
        cnt  <= SQRT_STEPS_M1;
      end
      S_SQRT: begin
        rem  <= sub_ge ? sub_d[ROOT_W:0] : sqrt_rem_sh[ROOT_W:0];
        root <= {root[ROOT_W-2:0], sub_ge};
        rad  <= {rad[RAD_W-3:0], 2'b00};
        cnt  <= cnt - CNT_W'(1);
      end
      S_MUL: prod <= mul_p;
      S_DIV_LD: begin
        dvd  <= prod[DIV_W-1:0];
        drem <= '0;
        cnt  <= DIV_STEPS_M1;
      end
      S_DIV: begin
        drem <= sub_ge ? sub_d[ADC_W-1:0] : div_rem_sh[ADC_W-1:0];
        dvd  <= {dvd[DIV_W-2:0], sub_ge};
        cnt  <= cnt - CNT_W'(1);
      end
      S_STORE: begin
        if (job == JOB_CUR) begin
          cur_now <= q_signed;
        end
        if (job == JOB_VOLT) begin
          volt_now <= q_signed;
        end
      end
      S_DONE: begin
        if (!m_valid || m_axis_tready) begin
          out_cur_now  <= cur_now;
          out_volt_now <= volt_now;
          out_cur_rms  <= use_high ? hi_held : lo_held;
          out_volt_rms <= mv_held;
          out_high     <= use_high;
          out_closed   <= closed;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'b000000, out_volt_rms, out_cur_rms, out_volt_now, out_cur_now};
  assign m_axis_tlast  = out_closed;
  assign m_axis_tuser  = out_high;

  // checks on the sequencer and the shared units
  `BRK_ASSERT_NXT(a_busy_after_accept, in_accept, state == S_SQ, "request accepted but not started")
  `BRK_ASSERT_IMP(a_div_nonzero, state == S_DIV, divisor != '0, "division by zero scale")
  `BRK_ASSERT_IMP(a_sqrt_rem_bound, state == S_SQRT, rem <= {root, 1'b0}, "root remainder too big")
  `BRK_ASSERT_NXT(a_window_wrap, (state == S_ACC) && (ch == CH_MAINS) && (&wcount), wcount == '0, "window count did not wrap")

endmodule

@@ tb/rms_meter_checker.sv @@
// checker for the breaker rms meter: predicts every reading and compares it with the block's output
`timescale 1ns / 1ps

module rms_meter_checker
  import brkrms_pkg::*;
#(
  parameter int WINDOW_LOG2 = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADC_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // low_gain_sample[15:0], high_gain_sample[31:16], mains_sample[47:32]
  input  logic [47:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // current_now[26:0], voltage_now[53:27], current_rms[79:54], voltage_rms[105:80]
  input  logic [111:0]         m_axis_tdata,
  input  logic                 m_axis_tlast,
  // high_gain_used[0]
  input  logic [0:0]           m_axis_tuser,
  output int                   mismatches,
  output int                   readings_owed
);

  localparam logic [15:0] SEL_FLOOR = 16'd100;
  localparam logic [15:0] SEL_CEIL  = 16'd65435;
  localparam logic [63:0] MILLI_PER_UNIT = 64'd1000;

  typedef struct packed {
    logic signed [26:0] current_now;
    logic signed [26:0] voltage_now;
    logic [25:0]        current_rms;
    logic [25:0]        voltage_rms;
    logic               high_gain_used;
    logic               rms_updated;
  } meter_reading_t;

  meter_reading_t readings_due[$];

  // calibration copy
  logic [15:0] lg_off, lg_scale, hg_off, hg_scale, mv_off, mv_scale;
  // window state
  logic [38:0] lg_sum, hg_sum, mv_sum;
  logic [6:0]  ticks_in_window;
  logic [25:0] lg_held, hg_held, mv_held;

  function automatic logic [63:0] abs_dev(input logic [15:0] raw, input logic [15:0] off);
    return (raw < off) ? 64'(off - raw) : 64'(raw - off);
  endfunction

  function automatic logic [63:0] to_milli(input logic [63:0] mag, input logic [15:0] scale);
    // a scale of zero behaves as one
    return mag * MILLI_PER_UNIT / ((scale == 16'd0) ? 64'd1 : 64'(scale));
  endfunction

  function automatic logic signed [26:0] milli_now(input logic [15:0] raw,
                                                    input logic [15:0] off,
                                                    input logic [15:0] scale);
    logic [63:0] q;
    q = to_milli(abs_dev(raw, off), scale);
    if (raw < off) q = -q;
    return q[26:0];
  endfunction

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, probe;
    rem   = v;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [25:0] window_rms(input logic [38:0] sum, input logic [15:0] scale);
    logic [63:0] mean;
    mean = 64'(sum) >> WINDOW_LOG2;
    return 26'(to_milli(64'(floor_sqrt(mean)), scale));
  endfunction

  function automatic meter_reading_t next_reading(input logic [15:0] lo, input logic [15:0] hi,
                                                  input logic [15:0] mv);
    meter_reading_t r;
    logic           high_sel;
    logic [63:0]    dev;
    high_sel = !(lo > SEL_FLOOR && lo < SEL_CEIL);
    dev    = abs_dev(lo, lg_off);
    lg_sum = lg_sum + 39'(dev * dev);
    dev    = abs_dev(hi, hg_off);
    hg_sum = hg_sum + 39'(dev * dev);
    dev    = abs_dev(mv, mv_off);
    mv_sum = mv_sum + 39'(dev * dev);
    // the closing tick adds its square first, then refreshes the held values
    r.rms_updated = (ticks_in_window >= 7'((1 << WINDOW_LOG2) - 1));
    if (r.rms_updated) begin
      lg_held = window_rms(lg_sum, lg_scale);
      hg_held = window_rms(hg_sum, hg_scale);
      mv_held = window_rms(mv_sum, mv_scale);
      lg_sum = '0;
      hg_sum = '0;
      mv_sum = '0;
      ticks_in_window = '0;
    end else begin
      ticks_in_window = ticks_in_window + 7'd1;
    end
    r.current_now    = high_sel ? milli_now(hi, hg_off, hg_scale) : milli_now(lo, lg_off, lg_scale);
    r.voltage_now    = milli_now(mv, mv_off, mv_scale);
    r.current_rms    = high_sel ? hg_held : lg_held;
    r.voltage_rms    = mv_held;
    r.high_gain_used = high_sel;
    return r;
  endfunction

  task automatic check_field(input string label, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    meter_reading_t want, got;
    if (rst) begin
      lg_off   <= 16'd32768;
      lg_scale <= 16'd874;
      hg_off   <= 16'd32768;
      hg_scale <= 16'd8738;
      mv_off   <= 16'd32768;
      mv_scale <= 16'd79;
      lg_sum = '0;
      hg_sum = '0;
      mv_sum = '0;
      ticks_in_window = '0;
      lg_held = '0;
      hg_held = '0;
      mv_held = '0;
      readings_due.delete();
      mismatches = 0;
      readings_owed <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LG_OFFSET: lg_off   <= cfg_data;
          REG_LG_SCALE:  lg_scale <= cfg_data;
          REG_HG_OFFSET: hg_off   <= cfg_data;
          REG_HG_SCALE:  hg_scale <= cfg_data;
          REG_MV_OFFSET: mv_off   <= cfg_data;
          REG_MV_SCALE:  mv_scale <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (readings_due.size() == 0) begin
          mismatches++;
          $display("%0t: reading with none expected, expected nothing, actual %h", $time,
                   m_axis_tdata);
        end else begin
          want = readings_due.pop_front();
          got.current_now    = m_axis_tdata[26:0];
          got.voltage_now    = m_axis_tdata[53:27];
          got.current_rms    = m_axis_tdata[79:54];
          got.voltage_rms    = m_axis_tdata[105:80];
          got.high_gain_used = m_axis_tuser[0];
          got.rms_updated    = m_axis_tlast;
          check_field("current_now", longint'(want.current_now), longint'(got.current_now));
          check_field("voltage_now", longint'(want.voltage_now), longint'(got.voltage_now));
          check_field("current_rms", longint'(want.current_rms), longint'(got.current_rms));
          check_field("voltage_rms", longint'(want.voltage_rms), longint'(got.voltage_rms));
          check_field("high_gain_used", longint'(want.high_gain_used),
                      longint'(got.high_gain_used));
          check_field("rms_updated", longint'(want.rms_updated), longint'(got.rms_updated));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        readings_due.push_back(next_reading(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                            s_axis_tdata[47:32]));
      readings_owed <= readings_due.size();
    end
  end

endmodule

@@ tb/tb_breaker_current_voltage_rms_meter.sv @@
// testbench top for the breaker rms meter: stimulus, calibration phases and verdict
`timescale 1ns / 1ps

module tb_breaker_current_voltage_rms_meter;
  import brkrms_pkg::*;

  localparam int WINDOW_LOG2 = 6;
  // several times the longest gap between requests, which a closing tick makes
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 250;

  // indexes past the last register, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // channel selection edges on the low-gain code
  localparam logic [15:0] SEL_FLOOR = 16'd100;
  localparam logic [15:0] SEL_CEIL  = 16'd65435;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADC_W-1:0]     cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // low_gain_sample[15:0], high_gain_sample[31:16], mains_sample[47:32]
  logic [47:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // current_now[26:0], voltage_now[53:27], current_rms[79:54], voltage_rms[105:80]
  logic [111:0]         m_axis_tdata;
  // rms_updated
  logic                 m_axis_tlast;
  // high_gain_used[0]
  logic [0:0]           m_axis_tuser;

  int mismatches;
  int readings_owed;

  // idle percentages of each side, changed per phase
  int src_idle_pct = 22;
  int sink_idle_pct = 65;

  // current offsets, so that samples can be clustered around the zero point
  logic [15:0] lg_centre = 16'd32768;
  logic [15:0] hg_centre = 16'd32768;
  logic [15:0] mv_centre = 16'd32768;

  breaker_current_voltage_rms_meter #(
    .WINDOW_LOG2(WINDOW_LOG2)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  rms_meter_checker #(
    .WINDOW_LOG2(WINDOW_LOG2)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .mismatches(mismatches),
    .readings_owed(readings_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: back-pressure decided afresh on every falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // watchdog: too long without any request moving on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** breaker_current_voltage_rms_meter: FAILED **");
    $finish;
  end

  // one tick of samples; entered and left on a falling edge, valid stays high between
  // back-to-back requests so it is never dropped and raised in the same step
  task automatic push_tick(input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] mv);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mv, hi, lo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every reading in flight has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (readings_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // full calibration set; only called with the block idle
  task automatic load_calibration(input logic [15:0] lg_off, input logic [15:0] lg_sc,
                                  input logic [15:0] hg_off, input logic [15:0] hg_sc,
                                  input logic [15:0] mv_off, input logic [15:0] mv_sc);
    write_reg(REG_LG_OFFSET, lg_off);
    write_reg(REG_LG_SCALE, lg_sc);
    write_reg(REG_HG_OFFSET, hg_off);
    write_reg(REG_HG_SCALE, hg_sc);
    write_reg(REG_MV_OFFSET, mv_off);
    write_reg(REG_MV_SCALE, mv_sc);
    cfg_we <= 1'b0;
    @(negedge clk);
    lg_centre = lg_off;
    hg_centre = hg_off;
    mv_centre = mv_off;
  endtask

  task automatic load_random_calibration();
    load_calibration(16'($urandom), 16'($urandom_range(0, 65535)),
                     16'($urandom), 16'($urandom_range(0, 65535)),
                     16'($urandom), 16'($urandom_range(0, 65535)));
  endtask

  // sample code: half uniform, the rest extremes, selection edges and near-offset values
  function automatic logic [15:0] pick_code(input logic [15:0] centre);
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: begin
        case ($urandom_range(0, 3))
          0: return SEL_FLOOR;
          1: return SEL_FLOOR + 16'd1;
          2: return SEL_CEIL - 16'd1;
          default: return SEL_CEIL;
        endcase
      end
      3, 4, 5: return centre + 16'($urandom_range(0, 4000)) - 16'd2000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed ticks on the reset calibration
    push_tick(16'd32768, 16'd32768, 16'd32768);  // all at the zero point
    push_tick(16'h0000, 16'h0000, 16'h0000);
    push_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_tick(SEL_FLOOR, 16'd1234, 16'd40000);   // on the lower edge: high gain
    push_tick(SEL_FLOOR + 16'd1, 16'd20000, 16'd30000);  // just inside: low gain
    push_tick(SEL_CEIL - 16'd1, 16'd50000, 16'd25000);
    push_tick(SEL_CEIL, 16'd60000, 16'd32767);   // on the upper edge: high gain
    push_tick(16'd32769, 16'd32767, 16'd32767);
    settle();

    // extreme calibration, zero scale on the low-gain channel
    load_calibration(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF);
    // writes past the last register must leave everything alone
    write_reg(IDX_SPARE_LO, 16'hFFFF);
    write_reg(IDX_SPARE_HI, 16'h0000);
    cfg_we <= 1'b0;
    @(negedge clk);
    push_tick(16'hFFFF, 16'h0000, 16'hFFFF);
    push_tick(16'h0000, 16'h0000, 16'h0000);
    push_tick(SEL_FLOOR + 16'd1, 16'hFFFF, 16'h0001);
    push_tick(SEL_CEIL - 16'd1, 16'd12345, 16'd54321);
    push_tick(SEL_FLOOR, 16'h0000, 16'h0000);
    push_tick(SEL_CEIL, 16'hFFFF, 16'hFFFF);
    push_tick(16'hAAAA, 16'h5555, 16'hAAAA);
    push_tick(16'h5555, 16'hAAAA, 16'h5555);
    settle();

    // zero scale on the other two channels, widest scale on low gain
    load_calibration(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    push_tick(16'h0000, 16'hFFFF, 16'h0000);
    push_tick(16'hFFFF, 16'h0001, 16'hFFFE);
    push_tick(16'd32768, 16'd32768, 16'd32768);
    push_tick(SEL_FLOOR + 16'd1, 16'h8000, 16'h7FFF);
    settle();

    // random phases: sender-light, receiver-light, then no idling at all
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct = 65;
          load_calibration(16'd32768 + 16'($urandom_range(0, 4000)) - 16'd2000,
                           16'($urandom_range(50, 9000)),
                           16'd32768 + 16'($urandom_range(0, 4000)) - 16'd2000,
                           16'($urandom_range(50, 9000)),
                           16'd32768 + 16'($urandom_range(0, 4000)) - 16'd2000,
                           16'($urandom_range(50, 9000)));
        end
        1: begin
          src_idle_pct  = 65;
          sink_idle_pct = 22;
          load_random_calibration();
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          // largest possible deviations; finest scale on lg and mains, widest on hg
          load_calibration(16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          settle();
          load_random_calibration();
        end else if ($urandom_range(0, 59) == 0) begin
          // hold off until the pipeline has fully emptied
          settle();
        end
        push_tick(pick_code(lg_centre), pick_code(hg_centre), pick_code(mv_centre));
      end
      settle();
    end

    // anything still arriving now is unexpected
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && readings_owed == 0)
      $display("** breaker_current_voltage_rms_meter: PASSED **");
    else
      $display("** breaker_current_voltage_rms_meter: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/brkrms_pkg.sv
src/breaker_current_voltage_rms_meter.sv
tb/rms_meter_checker.sv
tb/tb_breaker_current_voltage_rms_meter.sv
